// File: design/lmsd_pkg.sv
// Shared types and constants for the LED matrix scan driver.
// No dependencies; the interfaces, the top level, the front end and the back end use this package.
`default_nettype none

package lmsd_pkg;

   localparam int COLOR_W = 3;

   // item opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_FILL = 1'b1;

   // any color code with this bit set is transparent
   localparam int TRANSPARENT_BIT = 3;

   localparam logic [15:0] DISPLAY_TICKS_RESET = 16'd50;

   typedef struct packed {
      logic       opcode;
      logic [4:0] x;
      logic [3:0] y;
      logic [5:0] width;
      logic [4:0] height;
      logic [3:0] color;
   } req_item_type;

   typedef struct packed {
      logic       red_top;
      logic       green_top;
      logic       blue_top;
      logic       red_bottom;
      logic       green_bottom;
      logic       blue_bottom;
      logic       shift_clock;
      logic       latch_pulse;
      logic       blank;
      logic [2:0] row_address;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/lmsd_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on lmsd_pkg for the payload types.
`default_nettype none

interface lmsd_req_if;
   logic                  valid;
   logic                  ready;
   lmsd_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lmsd_rsp_if;
   logic                  valid;
   logic                  ready;
   lmsd_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/led_matrix_scan_driver.sv
// Top level of the LED matrix scan driver: config register, front end, queue, back end.
// Depends on lmsd_pkg, lmsd_if, lmsd_front, lmsd_queue and lmsd_back.
`default_nettype none

// Drives a dual-half RGB LED panel of COLUMNS x 2*ROW_PAIRS pixels with 3-bit color.
// Each request item is either a scan tick, which yields exactly one pin word on the
// response channel, or a fill, which paints a clipped rectangle and yields nothing.
// The front end takes one item per cycle while its four-entry queue has room; ticks
// run through the back end at one per cycle while no fill is busy and the response
// channel is ready, so a steady tick stream sustains one item per clock. A fill holds
// the back end while it paints its clipped width: the frame store keeps one word per
// column, and the single write port paints every row of one column per cycle.
// Transparent or empty fills are dropped in the front end and cost nothing downstream.
// After reset the screen reads black at once: a valid bit per column stands in for
// clearing, so there is no clearing pass. Write display_ticks only while idle.
module led_matrix_scan_driver #(
   parameter int COLUMNS = 32,
   parameter int ROW_PAIRS = 8
) (
   input  logic        clock,
   input  logic        reset,
   lmsd_req_if.sink    req_chan,
   lmsd_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import lmsd_pkg::*;

   localparam int SCREEN_ROWS = 2 * ROW_PAIRS;
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int XE_W        = $clog2(COLUMNS + 1);
   localparam int CMD_W       = 1 + COL_W + XE_W + SCREEN_ROWS + COLOR_W;
   localparam int QUEUE_DEPTH = 4;

   // lit ticks per row pair; takes effect at once
   logic [15:0] display_ticks_ff;

   // front to queue
   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_full;

   // queue to back
   logic             q_pop;
   logic             q_head_valid;
   logic [CMD_W-1:0] q_head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_ticks_ff <= DISPLAY_TICKS_RESET;
      end else if (csr_write_enable) begin
         display_ticks_ff <= csr_write_data;
      end
   end

   // classify and clip; push only items that do something in the back end
   lmsd_front #(
      .COLUMNS   (COLUMNS),
      .ROW_PAIRS (ROW_PAIRS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   // decouple acceptance from fill and scan work
   lmsd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // paint the frame store and sequence shift, latch and lit ticks
   lmsd_back #(
      .COLUMNS   (COLUMNS),
      .ROW_PAIRS (ROW_PAIRS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .display_ticks (display_ticks_ff),
      .head_valid    (q_head_valid),
      .head_data     (q_head_data),
      .pop           (q_pop),
      .rsp_chan      (rsp_chan)
   );

`ifndef SYNTHESIS
   // the front end must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   // the back end pops only a present item
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("queue pop while empty");

   // color data is driven only on shift ticks
   a_dark_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.data.shift_clock) |->
         !(rsp_chan.data.red_top || rsp_chan.data.green_top || rsp_chan.data.blue_top ||
           rsp_chan.data.red_bottom || rsp_chan.data.green_bottom ||
           rsp_chan.data.blue_bottom))
      else $error("color data on a non-shift tick");

   // a latch tick is blanked and carries no shift clock
   a_latch_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.latch_pulse) |->
         (rsp_chan.data.blank && !rsp_chan.data.shift_clock))
      else $error("latch tick not blanked or shifting");
`endif

endmodule

`default_nettype wire

// File: design/lmsd_front.sv
// Front end: accepts request items, clips fill rectangles and drops no-op fills.
// Depends on lmsd_pkg and lmsd_req_if; feeds lmsd_queue.
`default_nettype none

module lmsd_front #(
   parameter int COLUMNS = 32,
   parameter int ROW_PAIRS = 8,
   localparam int SCREEN_ROWS = 2 * ROW_PAIRS,
   localparam int COL_W = $clog2(COLUMNS),
   localparam int XE_W = $clog2(COLUMNS + 1),
   localparam int CMD_W = 1 + COL_W + XE_W + SCREEN_ROWS + lmsd_pkg::COLOR_W
) (
   lmsd_req_if.sink          req_chan,
   input  logic              queue_full,
   output logic              push,
   output logic [CMD_W-1:0]  push_data
);
   import lmsd_pkg::*;

   localparam int SUM_W = (XE_W > 7) ? XE_W : 7;

   typedef struct packed {
      logic                   is_fill;
      logic [COL_W-1:0]       x_start;
      logic [XE_W-1:0]        x_end;
      logic [SCREEN_ROWS-1:0] row_mask;
      logic [COLOR_W-1:0]     color;
   } cmd_type;

   cmd_type          cmd;
   logic [SUM_W-1:0] x_ext;
   logic [SUM_W-1:0] x_sum;
   logic [5:0]       y_sum;
   logic             x_on;
   logic             keep_fill;

   always_comb begin
      x_ext = SUM_W'(req_chan.data.x);
      x_sum = x_ext + SUM_W'(req_chan.data.width);
      y_sum = 6'(req_chan.data.y) + 6'(req_chan.data.height);
      x_on  = x_ext < SUM_W'(COLUMNS);

      cmd = '0;
      cmd.is_fill = (req_chan.data.opcode == OP_FILL);
      cmd.x_start = COL_W'(req_chan.data.x);
      cmd.x_end   = (x_sum > SUM_W'(COLUMNS)) ? XE_W'(COLUMNS) : XE_W'(x_sum);
      cmd.color   = req_chan.data.color[COLOR_W-1:0];
      // rows past the bottom edge simply have no mask bit
      for (int r = 0; r < SCREEN_ROWS; r++) begin
         cmd.row_mask[r] = (r >= int'(req_chan.data.y)) && (r < int'(y_sum));
      end

      keep_fill = !req_chan.data.color[TRANSPARENT_BIT] && x_on &&
                  (req_chan.data.width != 6'd0) && (cmd.row_mask != '0);
   end

   // drop fills that touch no pixel; they are still accepted
   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full && (!cmd.is_fill || keep_fill);
   assign push_data = cmd;

endmodule

`default_nettype wire

// File: design/lmsd_queue.sv
// Small register queue between the front and back ends.
// No package dependency; width and depth come from parameters.
`default_nettype none

module lmsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/lmsd_back.sv
// Back end: frame store, column-wise fill engine, scan sequencer and output register.
// Depends on lmsd_pkg and lmsd_rsp_if; drained from lmsd_queue.
`default_nettype none

module lmsd_back #(
   parameter int COLUMNS = 32,
   parameter int ROW_PAIRS = 8,
   localparam int SCREEN_ROWS = 2 * ROW_PAIRS,
   localparam int COL_W = $clog2(COLUMNS),
   localparam int XE_W = $clog2(COLUMNS + 1),
   localparam int CMD_W = 1 + COL_W + XE_W + SCREEN_ROWS + lmsd_pkg::COLOR_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      display_ticks,
   input  logic             head_valid,
   input  logic [CMD_W-1:0] head_data,
   output logic             pop,
   lmsd_rsp_if.source       rsp_chan
);
   import lmsd_pkg::*;

   localparam int ROW_W  = $clog2(ROW_PAIRS);
   localparam int WORD_W = SCREEN_ROWS * COLOR_W;

   typedef struct packed {
      logic                   is_fill;
      logic [COL_W-1:0]       x_start;
      logic [XE_W-1:0]        x_end;
      logic [SCREEN_ROWS-1:0] row_mask;
      logic [COLOR_W-1:0]     color;
   } cmd_type;

   typedef enum logic [1:0] {
      PH_SHIFT,
      PH_LATCH,
      PH_LIT
   } phase_type;

   cmd_type head;
   assign head = head_data;

   // fill engine
   logic             active_ff;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] fill_col;
   logic             fill_last;
   logic             fill_step;

   // frame store: one word per column holds every row of that column
   logic [WORD_W-1:0]  mem [COLUMNS];
   logic [COLUMNS-1:0] col_valid_ff;
   logic [WORD_W-1:0]  rd_word_ff;

   // scan sequencer
   phase_type        phase_ff;
   logic [COL_W-1:0] scan_col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [15:0]      lit_ff;
   logic [15:0]      lit_next;

   // read stage and output register
   logic             s1_valid_ff;
   logic             s1_shift_ff;
   logic             s1_latch_ff;
   logic             s1_blank_ff;
   logic             s1_col_valid_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_move;
   logic             tick_step;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_data_ff;
   logic [COLOR_W-1:0] top_px;
   logic [COLOR_W-1:0] bot_px;
   logic             show_px;

   assign fill_col  = active_ff ? col_ff : head.x_start;
   assign fill_last = (XE_W'(fill_col) + XE_W'(1)) == head.x_end;
   assign fill_step = head_valid && head.is_fill;

   assign s1_move   = !rsp_valid_ff || rsp_chan.ready;
   assign tick_step = head_valid && !head.is_fill && (!s1_valid_ff || s1_move);
   assign pop       = (fill_step && fill_last) || tick_step;

   assign lit_next  = lit_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fill_step) begin
         active_ff <= !fill_last;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_step) begin
         col_ff <= fill_col + COL_W'(1);
      end
   end

   // a column never written reads as black; its first write covers the whole word
   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
      end else if (fill_step) begin
         col_valid_ff[fill_col] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_step) begin
         for (int r = 0; r < SCREEN_ROWS; r++) begin
            if (!col_valid_ff[fill_col] || head.row_mask[r]) begin
               mem[fill_col][r*COLOR_W +: COLOR_W] <= head.row_mask[r] ? head.color : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_step) begin
         rd_word_ff <= mem[scan_col_ff];
      end
   end

   always_comb begin
      top_px  = rd_word_ff[int'(s1_row_ff) * COLOR_W +: COLOR_W];
      bot_px  = rd_word_ff[(int'(s1_row_ff) + ROW_PAIRS) * COLOR_W +: COLOR_W];
      show_px = s1_shift_ff && s1_col_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SHIFT;
         scan_col_ff  <= '0;
         row_ff       <= '0;
         lit_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (tick_step) begin
            s1_valid_ff     <= 1'b1;
            s1_row_ff       <= row_ff;
            s1_col_valid_ff <= col_valid_ff[scan_col_ff];
            s1_shift_ff     <= (phase_ff == PH_SHIFT);
            s1_latch_ff     <= (phase_ff == PH_LATCH);
            s1_blank_ff     <= (phase_ff != PH_LIT);
            unique case (phase_ff)
               PH_SHIFT: begin
                  if (scan_col_ff == COL_W'(COLUMNS - 1)) begin
                     scan_col_ff <= '0;
                     phase_ff    <= PH_LATCH;
                  end else begin
                     scan_col_ff <= scan_col_ff + COL_W'(1);
                  end
               end
               PH_LATCH: begin
                  lit_ff   <= '0;
                  phase_ff <= PH_LIT;
               end
               PH_LIT: begin
                  // a zero count ends the row after one lit tick, like a count of one
                  if (lit_next >= display_ticks) begin
                     lit_ff      <= '0;
                     scan_col_ff <= '0;
                     row_ff      <= (row_ff == ROW_W'(ROW_PAIRS - 1)) ? '0 : row_ff + ROW_W'(1);
                     phase_ff    <= PH_SHIFT;
                  end else begin
                     lit_ff <= lit_next;
                  end
               end
               default: begin
                  phase_ff <= PH_SHIFT;
               end
            endcase
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_move) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               rsp_data_ff.red_top      <= show_px && top_px[0];
               rsp_data_ff.green_top    <= show_px && top_px[1];
               rsp_data_ff.blue_top     <= show_px && top_px[2];
               rsp_data_ff.red_bottom   <= show_px && bot_px[0];
               rsp_data_ff.green_bottom <= show_px && bot_px[1];
               rsp_data_ff.blue_bottom  <= show_px && bot_px[2];
               rsp_data_ff.shift_clock  <= s1_shift_ff;
               rsp_data_ff.latch_pulse  <= s1_latch_ff;
               rsp_data_ff.blank        <= s1_blank_ff;
               rsp_data_ff.row_address  <= 3'(s1_row_ff);
            end
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

`default_nettype wire
